>>> design/antenna_pattern_interpolator_macros.svh
// assertion helpers for the design files that check themselves
`ifndef ANTENNA_PATTERN_INTERPOLATOR_MACROS_SVH
`define ANTENNA_PATTERN_INTERPOLATOR_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define API_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain invariant checked on every rising clock edge outside reset
`define API_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

>>> design/api_pkg.sv
package api_pkg;

    localparam int ANGLE_W    = 16;
    localparam int SPAN_W     = 15;
    localparam int PTS_W      = 7;
    localparam int IDX_W      = 12;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int HALF_SHIFT = 6;
    localparam int RND_SHIFT  = 7;
    localparam int MUL_W      = SAMPLE_W + SPAN_W + 2;
    localparam int SUM_W      = MUL_W + 1;
    localparam int N2_W       = SUM_W - RND_SHIFT;
    localparam int G_W        = N2_W + 2;

    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    localparam t_cfg_idx CFG_HSPAN = 2'd0;
    localparam t_cfg_idx CFG_VSPAN = 2'd1;
    localparam t_cfg_idx CFG_GPTS  = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [SPAN_W-1:0] HSPAN_RST = 15'd5760;
    localparam logic [SPAN_W-1:0] VSPAN_RST = 15'd5760;
    localparam logic [PTS_W-1:0]  GPTS_RST  = 7'd64;

    localparam t_sample SAMPLE_MAX = 16'sh7fff;
    localparam t_sample SAMPLE_MIN = -16'sh8000;

    typedef struct packed {
        logic                op;
        logic [IDX_W-1:0]    idx;
        logic [SAMPLE_W-1:0] val;
    } t_req;

    typedef struct packed {
        t_sample d;
        logic    neg;
        logic    oor;
    } t_fin;

endpackage

>>> design/antenna_pattern_interpolator.sv
// throughput: one request per cycle, busy stays low; the depth comes from the
//   pipelined restoring dividers (cell index per axis and correction) and the table read
// reset: synchronous, clears the pipeline valids and loads the default registers;
//   pattern table contents are kept and undefined until written
`include "antenna_pattern_interpolator_macros.svh"

module antenna_pattern_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_op,
    input  logic [api_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [api_pkg::SAMPLE_W-1:0] i_entry_value,
    input  logic signed [api_pkg::ANGLE_W-1:0] i_horiz_angle,
    input  logic signed [api_pkg::ANGLE_W-1:0] i_vert_angle,
    input  logic                               i_cfg_we,
    input  logic [api_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [api_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    output logic signed [api_pkg::SAMPLE_W-1:0] o_gain,
    output logic                               o_out_of_range
);

    localparam int PW    = $clog2(MAX_POINTS);
    localparam int DEPTH = MAX_POINTS * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = ((AW > api_pkg::IDX_W) ? AW : api_pkg::IDX_W) + 1;
    localparam int GW    = ((PW + 1 > api_pkg::PTS_W) ? PW + 1 : api_pkg::PTS_W) + 1;
    localparam int PRD_W = api_pkg::ANGLE_W + PW;
    localparam int LAT   = 36 + PW;

    // configuration
    logic [api_pkg::SPAN_W-1:0] r_hspan, r_vspan;
    logic [api_pkg::PTS_W-1:0]  r_gpts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hspan <= api_pkg::HSPAN_RST;
            r_vspan <= api_pkg::VSPAN_RST;
            r_gpts  <= api_pkg::GPTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                api_pkg::CFG_HSPAN: r_hspan <= i_cfg_data;
                api_pkg::CFG_VSPAN: r_vspan <= i_cfg_data;
                api_pkg::CFG_GPTS:  r_gpts  <= i_cfg_data[api_pkg::PTS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [api_pkg::SPAN_W-1:0] hs_eff, vs_eff;
    logic [GW-1:0]              gp_w, pts_w;
    logic [PW:0]                pts;
    logic [PW-1:0]              p;

    always_comb begin
        hs_eff = (r_hspan == '0) ? api_pkg::SPAN_W'(1) : r_hspan;
        vs_eff = (r_vspan == '0) ? api_pkg::SPAN_W'(1) : r_vspan;
        gp_w   = GW'(r_gpts);
        if (gp_w < GW'(2)) begin
            pts_w = GW'(2);
        end else if (gp_w > GW'(MAX_POINTS)) begin
            pts_w = GW'(MAX_POINTS);
        end else begin
            pts_w = gp_w;
        end
        pts = pts_w[PW:0];
        p   = PW'(pts - 1'b1);
    end

    assign busy = 1'b0;

    // stage 1: magnitudes and span check
    logic [api_pkg::ANGLE_W-1:0] ah, av;
    logic                        accept;

    assign accept = start && !busy;
    assign ah = i_horiz_angle[api_pkg::ANGLE_W-1] ?
                api_pkg::ANGLE_W'(-i_horiz_angle) : api_pkg::ANGLE_W'(i_horiz_angle);
    assign av = i_vert_angle[api_pkg::ANGLE_W-1] ?
                api_pkg::ANGLE_W'(-i_vert_angle) : api_pkg::ANGLE_W'(i_vert_angle);

    logic                        r1_valid, r1_oor;
    api_pkg::t_req               r1_req;
    logic [api_pkg::ANGLE_W-1:0] r1_ah, r1_av;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_req.op  <= i_op;
        r1_req.idx <= i_entry_index;
        r1_req.val <= i_entry_value;
        r1_ah      <= ah;
        r1_av      <= av;
        r1_oor     <= (ah > api_pkg::ANGLE_W'(hs_eff)) || (av > api_pkg::ANGLE_W'(vs_eff));
    end

    // stage 2: angle times grid intervals
    logic               r2_valid, r2_oor;
    api_pkg::t_req      r2_req;
    logic [PRD_W-1:0]   r2_hprod, r2_vprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_req   <= r1_req;
        r2_oor   <= r1_oor;
        r2_hprod <= PRD_W'(r1_ah) * PRD_W'(p);
        r2_vprod <= PRD_W'(r1_av) * PRD_W'(p);
    end

    // cell index and remainder per axis
    logic                       hdiv_valid, vdiv_valid, vdiv_oor;
    logic [PW-1:0]              hq, vq;
    logic [api_pkg::SPAN_W-1:0] hr, vr;
    api_pkg::t_req              hdiv_req;

    api_div #(
        .NUM_W (PRD_W),
        .DEN_W (api_pkg::SPAN_W),
        .QW    (PW),
        .PAY_W ($bits(api_pkg::t_req))
    ) u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_num   (r2_hprod),
        .i_den   (hs_eff),
        .i_pay   (r2_req),
        .o_valid (hdiv_valid),
        .o_quo   (hq),
        .o_rem   (hr),
        .o_pay   (hdiv_req)
    );

    api_div #(
        .NUM_W (PRD_W),
        .DEN_W (api_pkg::SPAN_W),
        .QW    (PW),
        .PAY_W (1)
    ) u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_num   (r2_vprod),
        .i_den   (vs_eff),
        .i_pay   (r2_oor),
        .o_valid (vdiv_valid),
        .o_quo   (vq),
        .o_rem   (vr),
        .o_pay   (vdiv_oor)
    );

    // stage 3: table addresses; writes travel with queries to keep order
    logic [AW-1:0] base;
    logic [IW-1:0] idx_ext;

    assign base    = AW'(vq) * AW'(pts) + AW'(hq);
    assign idx_ext = IW'(hdiv_req.idx);

    logic                       r3_valid, r3_query, r3_we, r3_eh, r3_ev, r3_oor;
    logic [AW-1:0]              r3_waddr, r3_a0, r3_a1, r3_a2;
    logic [api_pkg::SAMPLE_W-1:0] r3_wval;
    logic [api_pkg::SPAN_W-1:0] r3_rh, r3_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r3_we    <= 1'b0;
        end else begin
            r3_valid <= hdiv_valid && (hdiv_req.op == api_pkg::OP_QUERY);
            r3_we    <= hdiv_valid && (hdiv_req.op == api_pkg::OP_WRITE)
                        && (idx_ext < IW'(DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        r3_query <= (hdiv_req.op == api_pkg::OP_QUERY);
        r3_waddr <= idx_ext[AW-1:0];
        r3_wval  <= hdiv_req.val;
        r3_a0    <= base;
        r3_a1    <= base + AW'(1);
        r3_a2    <= base + AW'(pts);
        r3_eh    <= (hq >= p);
        r3_ev    <= (vq >= p);
        r3_rh    <= hr;
        r3_rv    <= vr;
        r3_oor   <= vdiv_oor;
    end

    // stage 4: three copies of the table, one read port each
    logic [api_pkg::SAMPLE_W-1:0] rd_d, rd_dh, rd_dv;

    api_mem #(.DEPTH(DEPTH), .AW(AW), .DW(api_pkg::SAMPLE_W)) u_mem_d (
        .i_clk (i_clk), .i_we (r3_we), .i_waddr (r3_waddr), .i_wdata (r3_wval),
        .i_raddr (r3_a0), .o_rdata (rd_d)
    );
    api_mem #(.DEPTH(DEPTH), .AW(AW), .DW(api_pkg::SAMPLE_W)) u_mem_h (
        .i_clk (i_clk), .i_we (r3_we), .i_waddr (r3_waddr), .i_wdata (r3_wval),
        .i_raddr (r3_a1), .o_rdata (rd_dh)
    );
    api_mem #(.DEPTH(DEPTH), .AW(AW), .DW(api_pkg::SAMPLE_W)) u_mem_v (
        .i_clk (i_clk), .i_we (r3_we), .i_waddr (r3_waddr), .i_wdata (r3_wval),
        .i_raddr (r3_a2), .o_rdata (rd_dv)
    );

    logic                       r4_valid, r4_eh, r4_ev, r4_oor;
    logic [api_pkg::SPAN_W-1:0] r4_rh, r4_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid && r3_query;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_eh  <= r3_eh;
        r4_ev  <= r3_ev;
        r4_oor <= r3_oor;
        r4_rh  <= r3_rh;
        r4_rv  <= r3_rv;
    end

    // stage 5: differences, neighbors past the edge read as zero
    api_pkg::t_sample            s_d, s_dh, s_dv;
    logic                        r5_valid, r5_oor;
    api_pkg::t_sample            r5_d;
    logic signed [api_pkg::SAMPLE_W:0] r5_ddh, r5_ddv;
    logic [api_pkg::SPAN_W-1:0]  r5_rh, r5_rv;

    assign s_d  = api_pkg::t_sample'(rd_d);
    assign s_dh = r4_eh ? api_pkg::t_sample'(0) : api_pkg::t_sample'(rd_dh);
    assign s_dv = r4_ev ? api_pkg::t_sample'(0) : api_pkg::t_sample'(rd_dv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_d   <= s_d;
        r5_ddh <= (api_pkg::SAMPLE_W+1)'(s_d) - (api_pkg::SAMPLE_W+1)'(s_dh);
        r5_ddv <= (api_pkg::SAMPLE_W+1)'(s_d) - (api_pkg::SAMPLE_W+1)'(s_dv);
        r5_rh  <= r4_rh;
        r5_rv  <= r4_rv;
        r5_oor <= r4_oor;
    end

    // stage 6: weighted differences
    logic                                r6_valid, r6_oor;
    api_pkg::t_sample                    r6_d;
    logic signed [api_pkg::MUL_W-1:0]    r6_mh, r6_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_d   <= r5_d;
        r6_oor <= r5_oor;
        r6_mh  <= r5_ddh * $signed({1'b0, r5_rh});
        r6_mv  <= r5_ddv * $signed({1'b0, r5_rv});
    end

    // stage 7: sum plus half denominator, then the factor 128 as a shift
    logic [api_pkg::SUM_W-1:0] sum;

    assign sum = api_pkg::SUM_W'(r6_mh) + api_pkg::SUM_W'(r6_mv)
               + api_pkg::SUM_W'({p, {api_pkg::HALF_SHIFT{1'b0}}});

    logic                              r7_valid, r7_oor;
    api_pkg::t_sample                  r7_d;
    logic signed [api_pkg::N2_W-1:0]   r7_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_d   <= r6_d;
        r7_oor <= r6_oor;
        r7_n   <= sum[api_pkg::SUM_W-1:api_pkg::RND_SHIFT];
    end

    // stage 8: sign and magnitude for the unsigned divider
    logic                      r8_valid;
    api_pkg::t_fin             r8_fin;
    logic [api_pkg::N2_W-1:0]  r8_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else begin
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_fin.d   <= r7_d;
        r8_fin.oor <= r7_oor;
        r8_fin.neg <= r7_n[api_pkg::N2_W-1];
        r8_mag     <= r7_n[api_pkg::N2_W-1] ? api_pkg::N2_W'(-r7_n) : api_pkg::N2_W'(r7_n);
    end

    logic                     cdiv_valid;
    logic [api_pkg::N2_W-1:0] cq;
    logic [PW-1:0]            cr;
    api_pkg::t_fin            cdiv_fin;

    api_div #(
        .NUM_W (api_pkg::N2_W),
        .DEN_W (PW),
        .QW    (api_pkg::N2_W),
        .PAY_W ($bits(api_pkg::t_fin))
    ) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r8_valid),
        .i_num   (r8_mag),
        .i_den   (p),
        .i_pay   (r8_fin),
        .o_valid (cdiv_valid),
        .o_quo   (cq),
        .o_rem   (cr),
        .o_pay   (cdiv_fin)
    );

    // floor toward minus infinity for a negative numerator, then saturate
    logic signed [api_pkg::G_W-1:0] gx;
    api_pkg::t_sample               g_sat;

    always_comb begin
        if (cdiv_fin.neg) begin
            gx = api_pkg::G_W'(cdiv_fin.d) + $signed(api_pkg::G_W'(cq))
               + $signed(api_pkg::G_W'(cr != '0));
        end else begin
            gx = api_pkg::G_W'(cdiv_fin.d) - $signed(api_pkg::G_W'(cq));
        end
        if (gx > api_pkg::G_W'(api_pkg::SAMPLE_MAX)) begin
            g_sat = api_pkg::SAMPLE_MAX;
        end else if (gx < api_pkg::G_W'(api_pkg::SAMPLE_MIN)) begin
            g_sat = api_pkg::SAMPLE_MIN;
        end else begin
            g_sat = gx[api_pkg::SAMPLE_W-1:0];
        end
    end

    logic             r_valid, r_oor;
    api_pkg::t_sample r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= cdiv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oor  <= cdiv_fin.oor;
        r_gain <= cdiv_fin.oor ? api_pkg::t_sample'(0) : g_sat;
    end

    assign o_valid        = r_valid;
    assign o_gain         = r_gain;
    assign o_out_of_range = r_oor;

    `API_ASSERT_IMP(a_oor_gain_zero, o_valid && o_out_of_range, o_gain == '0, "out of range result with nonzero gain")
    `API_ASSERT_IMP(a_result_from_query, o_valid, $past(start && (i_op == api_pkg::OP_QUERY), LAT), "result without a matching query request")
    `API_ASSERT_ALWAYS(a_div_lockstep, hdiv_valid == vdiv_valid, "axis dividers out of step")

endmodule

>>> design/api_div.sv
module api_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 15,
    parameter int QW    = 6,
    parameter int PAY_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo,
    output logic [DEN_W-1:0] o_rem,
    output logic [PAY_W-1:0] o_pay
);

    localparam int WW = ((NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW) + 1;

    logic             r_valid [1:QW];
    logic [NUM_W-1:0] r_rem   [1:QW];
    logic [QW-1:0]    r_quo   [1:QW];
    logic [DEN_W-1:0] r_den   [1:QW];
    logic [PAY_W-1:0] r_pay   [1:QW];

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             valid_in;
        logic [NUM_W-1:0] rem_in;
        logic [QW-1:0]    quo_in;
        logic [DEN_W-1:0] den_in;
        logic [PAY_W-1:0] pay_in;
        logic [WW-1:0]    rem_w;
        logic [WW-1:0]    den_sh;
        logic             take;

        if (k == 0) begin : g_first
            assign valid_in = i_valid;
            assign rem_in   = i_num;
            assign quo_in   = '0;
            assign den_in   = i_den;
            assign pay_in   = i_pay;
        end else begin : g_next
            assign valid_in = r_valid[k];
            assign rem_in   = r_rem[k];
            assign quo_in   = r_quo[k];
            assign den_in   = r_den[k];
            assign pay_in   = r_pay[k];
        end

        assign rem_w  = WW'(rem_in);
        assign den_sh = WW'(den_in) << (QW - 1 - k);
        assign take   = (rem_w >= den_sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= take ? NUM_W'(rem_w - den_sh) : rem_in;
            r_quo[k+1] <= quo_in | (take ? (QW'(1) << (QW - 1 - k)) : QW'(0));
            r_den[k+1] <= den_in;
            r_pay[k+1] <= pay_in;
        end
    end

    assign o_valid = r_valid[QW];
    assign o_quo   = r_quo[QW];
    assign o_rem   = r_rem[QW][DEN_W-1:0];
    assign o_pay   = r_pay[QW];

endmodule

>>> design/api_mem.sv
module api_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sim/pattern_checker.sv
module pattern_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                i_op,
    input  logic [api_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [api_pkg::SAMPLE_W-1:0] i_entry_value,
    input  logic signed [api_pkg::ANGLE_W-1:0]  i_horiz_angle,
    input  logic signed [api_pkg::ANGLE_W-1:0]  i_vert_angle,
    input  logic                                i_cfg_we,
    input  logic [api_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [api_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                o_valid,
    input  logic signed [api_pkg::SAMPLE_W-1:0] o_gain,
    input  logic                                o_out_of_range,
    output int                                  o_pending,
    output int                                  o_errors,
    output int                                  o_queries,
    output int                                  o_oor_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import api_pkg::*;

    typedef struct packed {
        t_sample gain;
        logic    oor;
    } t_gain_result;

    t_sample             pattern_mem [4096];
    logic [SPAN_W-1:0]   hspan_q;
    logic [SPAN_W-1:0]   vspan_q;
    logic [PTS_W-1:0]    gpts_q;
    t_gain_result        gain_fifo [$];

    function automatic longint div_floor(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic t_gain_result predict_gain(logic signed [15:0] h,
                                                  logic signed [15:0] v);
        t_gain_result res;
        int hs, vs, pts, p, ah, av, ih, iv, rh, rv, base;
        longint d, dh, dv, num, den, g;
        hs  = (hspan_q == 0) ? 1 : int'(hspan_q);
        vs  = (vspan_q == 0) ? 1 : int'(vspan_q);
        pts = int'(gpts_q);
        if (pts < 2) pts = 2;
        if (pts > 64) pts = 64;
        p  = pts - 1;
        ah = (h < 0) ? -int'(h) : int'(h);
        av = (v < 0) ? -int'(v) : int'(v);
        res.gain = '0;
        res.oor  = 1'b1;
        if (ah > hs || av > vs) return res;
        ih = (ah * p) / hs;
        iv = (av * p) / vs;
        rh = ah * p - ih * hs;
        rv = av * p - iv * vs;
        base = iv * pts + ih;
        d  = pattern_mem[base];
        dh = (ih >= p) ? 0 : pattern_mem[base + 1];
        dv = (iv >= p) ? 0 : pattern_mem[base + pts];
        num = (d - dv) * rv + (d - dh) * rh;
        den = 128 * p;
        g = d - div_floor(num + den / 2, den);
        if (g > 32767) g = 32767;
        if (g < -32768) g = -32768;
        res.gain = t_sample'(g);
        res.oor  = 1'b0;
        return res;
    endfunction

    assign o_pending = gain_fifo.size();

    always @(posedge i_clk) begin
        t_gain_result exp_r;
        if (!i_rst_n) begin
            hspan_q <= HSPAN_RST;
            vspan_q <= VSPAN_RST;
            gpts_q  <= GPTS_RST;
            gain_fifo.delete();
            o_errors   <= 0;
            o_queries  <= 0;
            o_oor_seen <= 0;
        end else begin
            if (o_valid) begin
                if (gain_fifo.size() == 0) begin
                    $display("%0t: unexpected result gain=%0d oor=%0b",
                             $time, o_gain, o_out_of_range);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = gain_fifo.pop_front();
                    if (o_gain !== exp_r.gain || o_out_of_range !== exp_r.oor) begin
                        $display("%0t: mismatch expected gain=%0d oor=%0b, actual gain=%0d oor=%0b",
                                 $time, exp_r.gain, exp_r.oor, o_gain, o_out_of_range);
                        o_errors <= o_errors + 1;
                    end
                    if (exp_r.oor) o_oor_seen <= o_oor_seen + 1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HSPAN: hspan_q <= i_cfg_data;
                    CFG_VSPAN: vspan_q <= i_cfg_data;
                    CFG_GPTS:  gpts_q  <= i_cfg_data[PTS_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_op == OP_WRITE) begin
                    pattern_mem[i_entry_index] = i_entry_value;
                end else begin
                    gain_fifo.push_back(predict_gain(i_horiz_angle, i_vert_angle));
                    o_queries <= o_queries + 1;
                end
            end
        end
    end
endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import api_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 60;
    localparam int PHASE_ITEMS = 115;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_op = OP_WRITE;
    logic [IDX_W-1:0]     i_entry_index = '0;
    logic signed [15:0]   i_entry_value = '0;
    logic signed [15:0]   i_horiz_angle = '0;
    logic signed [15:0]   i_vert_angle = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_HSPAN;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                 o_valid;
    logic signed [15:0]   o_gain;
    logic                 o_out_of_range;
    int                   pending, errors, queries, oor_seen;
    int                   cycles = 0;
    int                   sent = 0;

    // stimulus-side view of the setup, used to keep reads on written entries
    bit                   written [4096];
    int                   cur_hs = 5760, cur_vs = 5760, cur_pts = 64;
    int                   idle_pct = 0;

    always #1 i_clk = ~i_clk;

    antenna_pattern_interpolator i_dut (.*);

    pattern_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_op, .i_entry_index, .i_entry_value,
        .i_horiz_angle, .i_vert_angle, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_valid, .o_gain, .o_out_of_range,
        .o_pending(pending), .o_errors(errors), .o_queries(queries),
        .o_oor_seen(oor_seen)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(logic op, logic [11:0] idx, logic signed [15:0] val,
                                logic signed [15:0] h, logic signed [15:0] v);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op = op;
        i_entry_index = idx;
        i_entry_value = val;
        i_horiz_angle = h;
        i_vert_angle = v;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
        if (op == OP_WRITE) written[idx] = 1'b1;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic write_entry(int idx);
        send_request(OP_WRITE, 12'(idx), rand_sample(), 16'($urandom()), 16'($urandom()));
    endtask

    // fill any cell the query would read that has never been written
    task automatic do_query(logic signed [15:0] h, logic signed [15:0] v);
        int ah, av, p, ih, iv, base, hs, vs, pts;
        hs = (cur_hs == 0) ? 1 : cur_hs;
        vs = (cur_vs == 0) ? 1 : cur_vs;
        pts = (cur_pts < 2) ? 2 : (cur_pts > 64) ? 64 : cur_pts;
        p = pts - 1;
        ah = (h < 0) ? -int'(h) : int'(h);
        av = (v < 0) ? -int'(v) : int'(v);
        if (ah <= hs && av <= vs) begin
            ih = (ah * p) / hs;
            iv = (av * p) / vs;
            base = iv * pts + ih;
            if (!written[base]) write_entry(base);
            if (ih < p && !written[base + 1]) write_entry(base + 1);
            if (iv < p && !written[base + pts]) write_entry(base + pts);
        end
        send_request(OP_QUERY, 12'($urandom()), 16'($urandom()), h, v);
    endtask

    function automatic logic signed [15:0] pick_angle(int span);
        int mag;
        case ($urandom_range(11))
            0: mag = span;
            1: mag = (span < 32767) ? span + 1 : span;
            2: mag = 0;
            3: return 16'($urandom());
            4: return -16'sh8000;
            default: mag = $urandom_range(0, (span == 0) ? 1 : span);
        endcase
        return $urandom_range(1) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic write_reg(t_cfg_idx idx, int val);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        // writes in flight leave no result, so let the pipeline empty out
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_HSPAN: cur_hs = val;
            CFG_VSPAN: cur_vs = val;
            default:   cur_pts = val & 7'h7f;
        endcase
    endtask

    initial begin
        int hs_set [9] = '{5760, 1, 32767, 0, 100, 32767, 20000, 3, 5760};
        int vs_set [9] = '{5760, 32767, 1, 50, 0, 32767, 777, 3, 12345};
        int pt_set [9] = '{64, 2, 64, 0, 127, 1, 17, 5, 33};
        int phase_end;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: corners, edges, the most negative angle, extreme samples
        send_request(OP_WRITE, 12'd4095, 16'sh7fff, 16'sh7fff, -16'sh8000);
        send_request(OP_WRITE, 12'd0, -16'sh8000, -16'sh8000, 16'sh7fff);
        send_request(OP_WRITE, 12'd1, 16'sh7fff, 16'sd0, 16'sd0);
        send_request(OP_WRITE, 12'd64, 16'sh7fff, 16'sd0, 16'sd0);
        do_query(16'sd0, 16'sd0);
        do_query(16'sd45, 16'sd45);
        do_query(-16'sd45, 16'sd90);
        do_query(16'sd5760, 16'sd5760);
        do_query(-16'sd5760, -16'sd5760);
        do_query(16'sd5761, 16'sd0);
        do_query(16'sd0, -16'sd5761);
        do_query(-16'sh8000, 16'sd0);
        do_query(16'sd0, -16'sh8000);
        do_query(16'sh7fff, 16'sh7fff);
        do_query(16'sd5759, 16'sd91);

        for (int ph = 0; ph < 9; ph++) begin
            idle_pct = (ph < 3) ? 30 : (ph < 6) ? 87 : 0;
            write_reg(CFG_HSPAN, hs_set[ph]);
            write_reg(CFG_VSPAN, vs_set[ph]);
            write_reg(CFG_GPTS, pt_set[ph]);
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) begin
                if ($urandom_range(3) == 0)
                    send_request(OP_WRITE, 12'($urandom()), rand_sample(),
                                 16'($urandom()), 16'($urandom()));
                else
                    do_query(pick_angle(cur_hs), pick_angle(cur_vs));
            end
            // hold off until the pipeline has returned everything
            start = 1'b0;
            while (pending != 0) @(negedge i_clk);
        end

        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        $display("run covered %0d queries (%0d out of range) over 9 span/grid settings",
                 queries, oor_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/api_pkg.sv
design/api_div.sv
design/api_mem.sv
design/antenna_pattern_interpolator.sv
sim/pattern_checker.sv
sim/tb_top.sv
